FILE: hw/rtl/drac_pkg.sv
// Shared types and constants for the debounced ADC range classifier.
package drac_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned RUN_W       = 8;
  localparam int unsigned CLASS_W     = 4;
  localparam int unsigned PAIR_W      = 64;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [CLASS_W-1:0]  CLASS_NONE      = 4'd8;
  localparam logic [SAMPLE_W-1:0] DISABLED_MIN    = 16'hFFFF;
  localparam logic [SAMPLE_W-1:0] RESET_THRESHOLD = 16'd20;
  localparam logic [RUN_W-1:0]    RESET_CONFIRM   = 8'd10;
  localparam logic [PAIR_W-1:0]   RESET_PAIR      = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_PAIR_0    = 3'd0,
    REG_RANGE_PAIR_1    = 3'd1,
    REG_RANGE_PAIR_2    = 3'd2,
    REG_RANGE_PAIR_3    = 3'd3,
    REG_TABLE_SELECTED  = 3'd4,
    REG_CHANGE_THRESHOLD = 3'd5,
    REG_CONFIRM_COUNT   = 3'd6
  } drac_reg_idx_t;

  typedef struct packed {
    logic                table_selected;
    logic [SAMPLE_W-1:0] change_threshold;
    logic [RUN_W-1:0]    confirm_count;
  } drac_cfg_t;

  typedef struct packed {
    logic               report;
    logic [CLASS_W-1:0] class_index;
  } drac_res_t;

endpackage

FILE: hw/rtl/debounced_adc_range_classifier.sv
// An accepted request passes from the input register to the result register.
// Throughput: one request per cycle while out_ready is high; the state update
// for one sample sits in the single stage between input and result registers.
// Reset (rst_n low, synchronous): windows disabled, table not selected,
// threshold 20, confirm count 10, accepted sample 0, run 0, class none.
// Top level of the debounced ADC range classifier.
module debounced_adc_range_classifier #(
  parameter int unsigned NUM_WINDOWS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [drac_pkg::SAMPLE_W-1:0]       in_adc_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_report,
  output logic [drac_pkg::CLASS_W-1:0]        out_class_index,
  input  logic                                cfg_we,
  input  logic [drac_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [drac_pkg::PAIR_W-1:0]         cfg_wdata
);

  localparam int unsigned NUM_PAIRS = (NUM_WINDOWS + 1) / 2;

  logic [drac_pkg::PAIR_W-1:0]   pair_r [NUM_PAIRS];
  drac_pkg::drac_cfg_t           cfg_r;

  logic                          s1_valid_r;
  logic [drac_pkg::SAMPLE_W-1:0] s1_sample_r;
  logic                          out_valid_r;
  drac_pkg::drac_res_t           out_res_r;
  drac_pkg::drac_res_t           res;
  logic                          s1_adv;

  // configuration registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
        pair_r[p] <= drac_pkg::RESET_PAIR;
      end
      cfg_r.table_selected   <= 1'b0;
      cfg_r.change_threshold <= drac_pkg::RESET_THRESHOLD;
      cfg_r.confirm_count    <= drac_pkg::RESET_CONFIRM;
    end else if (cfg_we) begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
        if (cfg_index == drac_pkg::CFG_IDX_W'(p)) begin
          pair_r[p] <= cfg_wdata;
        end
      end
      case (drac_pkg::drac_reg_idx_t'(cfg_index))
        drac_pkg::REG_TABLE_SELECTED:   cfg_r.table_selected   <= cfg_wdata[0];
        drac_pkg::REG_CHANGE_THRESHOLD: cfg_r.change_threshold <= cfg_wdata[15:0];
        drac_pkg::REG_CONFIRM_COUNT:    cfg_r.confirm_count    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample_r <= in_adc_sample;
    end
  end

  drac_core #(
    .NUM_WINDOWS (NUM_WINDOWS),
    .NUM_PAIRS   (NUM_PAIRS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_adv),
    .sample     (s1_sample_r),
    .cfg        (cfg_r),
    .range_pair (pair_r),
    .res        (res)
  );

  // result register: hold until taken, advance when the stage drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_report      = out_res_r.report;
  assign out_class_index = out_res_r.class_index;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_res_r))
    else $error("pending result overwritten");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_sample_r))
    else $error("input stage lost a request");

  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r.class_index <= drac_pkg::CLASS_NONE)
    else $error("result class out of range");

endmodule

FILE: hw/rtl/drac_classify.sv
// Window classifier: lowest enabled window that holds the sample.
module drac_classify #(
  parameter int unsigned NUM_WINDOWS = 8,
  parameter int unsigned NUM_PAIRS   = (NUM_WINDOWS + 1) / 2
) (
  input  logic [drac_pkg::SAMPLE_W-1:0] sample,
  input  logic [drac_pkg::PAIR_W-1:0]   range_pair [NUM_PAIRS],
  output logic [drac_pkg::CLASS_W-1:0]  class_index
);

  logic [NUM_WINDOWS-1:0]        hit;
  logic [drac_pkg::SAMPLE_W-1:0] win_min [NUM_WINDOWS];
  logic [drac_pkg::SAMPLE_W-1:0] win_max [NUM_WINDOWS];

  always_comb begin
    for (int w = 0; w < NUM_WINDOWS; w++) begin
      if ((w % 2) == 1) begin
        win_min[w] = range_pair[w / 2][47:32];
        win_max[w] = range_pair[w / 2][63:48];
      end else begin
        win_min[w] = range_pair[w / 2][15:0];
        win_max[w] = range_pair[w / 2][31:16];
      end
      hit[w] = (win_min[w] != drac_pkg::DISABLED_MIN) &&
               (sample >= win_min[w]) && (sample <= win_max[w]);
    end
  end

  // lowest index wins: scan from the top down
  always_comb begin
    class_index = drac_pkg::CLASS_NONE;
    for (int w = NUM_WINDOWS - 1; w >= 0; w--) begin
      if (hit[w]) begin
        class_index = drac_pkg::CLASS_W'(w);
      end
    end
  end

endmodule

FILE: hw/rtl/drac_core.sv
// Debounce state, run counter, class tracking and lock.
module drac_core #(
  parameter int unsigned NUM_WINDOWS = 8,
  parameter int unsigned NUM_PAIRS   = (NUM_WINDOWS + 1) / 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [drac_pkg::SAMPLE_W-1:0] sample,
  input  drac_pkg::drac_cfg_t           cfg,
  input  logic [drac_pkg::PAIR_W-1:0]   range_pair [NUM_PAIRS],
  output drac_pkg::drac_res_t           res
);

  logic [drac_pkg::SAMPLE_W-1:0] acc_r, acc_nxt;
  logic [drac_pkg::RUN_W-1:0]    run_r, run_nxt;
  logic [drac_pkg::CLASS_W-1:0]  class_r, class_nxt;

  logic [drac_pkg::CLASS_W-1:0]  new_class;
  logic [drac_pkg::SAMPLE_W:0]   delta;
  logic [drac_pkg::SAMPLE_W-1:0] diff;
  logic [drac_pkg::RUN_W-1:0]    run_inc;
  logic                          locked;
  logic                          report;

  drac_classify #(
    .NUM_WINDOWS (NUM_WINDOWS),
    .NUM_PAIRS   (NUM_PAIRS)
  ) u_classify (
    .sample      (sample),
    .range_pair  (range_pair),
    .class_index (new_class)
  );

  assign locked  = (class_r != drac_pkg::CLASS_NONE) && cfg.table_selected;
  assign delta   = {1'b0, sample} - {1'b0, acc_r};
  assign diff    = delta[drac_pkg::SAMPLE_W] ? (acc_r - sample) : delta[drac_pkg::SAMPLE_W-1:0];
  assign run_inc = run_r + 1'b1;

  always_comb begin
    acc_nxt   = acc_r;
    run_nxt   = run_r;
    class_nxt = class_r;
    report    = 1'b0;
    if (locked) begin
      report = 1'b1;
    end else if (diff > cfg.change_threshold) begin
      run_nxt = run_inc;
      // run reached the confirm count: take the sample and reclassify
      if (run_inc == cfg.confirm_count) begin
        run_nxt = '0;
        acc_nxt = sample;
        if (new_class != class_r) begin
          class_nxt = new_class;
          report    = 1'b1;
        end
      end
    end else begin
      run_nxt = '0;
    end
  end

  assign res.report      = report;
  assign res.class_index = class_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      run_r   <= '0;
      class_r <= drac_pkg::CLASS_NONE;
    end else if (step) begin
      acc_r   <= acc_nxt;
      run_r   <= run_nxt;
      class_r <= class_nxt;
    end
  end

  a_class_legal: assert property (@(posedge clk) disable iff (!rst_n)
    class_r <= drac_pkg::CLASS_NONE)
    else $error("class register out of range");

  a_lock_holds: assert property (@(posedge clk) disable iff (!rst_n)
    step && locked |=> $stable(class_r) && $stable(acc_r) && $stable(run_r))
    else $error("state moved while locked");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(class_r) && $stable(acc_r) && $stable(run_r))
    else $error("state moved without a request");

  a_accept_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
    step && !locked && (acc_nxt != acc_r) |=> run_r == '0)
    else $error("run not cleared on acceptance");

endmodule

FILE: tb/tb_debounced_adc_range_classifier.sv
`timescale 1ns / 1ps
// Self-checking testbench for the debounced ADC range classifier.
module tb_debounced_adc_range_classifier;

  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam logic [drac_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic [drac_pkg::CFG_IDX_W-1:0]  idx;
    logic [drac_pkg::PAIR_W-1:0]     data;
    logic                            typed;
    drac_pkg::drac_res_t             res;
  } script_row_t;

  localparam drac_pkg::drac_res_t NO_CHECK = '{1'b0, drac_pkg::CLASS_NONE};
  localparam int SCRIPT_LEN = 36;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{ROW_SAMPLE, REG_SPARE, 64'hFFFF, 1'b1, '{1'b0, drac_pkg::CLASS_NONE}},
    '{ROW_SAMPLE, REG_SPARE, 64'h0000, 1'b1, '{1'b0, drac_pkg::CLASS_NONE}},
    '{ROW_CFG, drac_pkg::REG_CONFIRM_COUNT, 64'd1, 1'b0, NO_CHECK},
    '{ROW_CFG, drac_pkg::REG_RANGE_PAIR_0, 64'hFFFF_8000_00FF_0000, 1'b0, NO_CHECK},
    '{ROW_CFG, drac_pkg::REG_CHANGE_THRESHOLD, 64'd0, 1'b0, NO_CHECK},
    '{ROW_SAMPLE, REG_SPARE, 64'hFFFF, 1'b1, '{1'b1, 4'd1}},
    '{ROW_SAMPLE, REG_SPARE, 64'hFFFF, 1'b1, '{1'b0, 4'd1}},
    '{ROW_SAMPLE, REG_SPARE, 64'h0000, 1'b1, '{1'b1, 4'd0}},
    '{ROW_SAMPLE, REG_SPARE, 64'h0100, 1'b1, '{1'b1, drac_pkg::CLASS_NONE}},
    '{ROW_SAMPLE, REG_SPARE, 64'h0100, 1'b1, '{1'b0, drac_pkg::CLASS_NONE}},
    '{ROW_SAMPLE, REG_SPARE, 64'h00FF, 1'b1, '{1'b1, 4'd0}},
    '{ROW_SAMPLE, REG_SPARE, 64'h8000, 1'b1, '{1'b1, 4'd1}},
    '{ROW_SAMPLE, REG_SPARE, 64'h7FFF, 1'b1, '{1'b1, drac_pkg::CLASS_NONE}},
    '{ROW_CFG, REG_SPARE, 64'h00FF_00FF_00FF_00FF, 1'b0, NO_CHECK},
    '{ROW_SAMPLE, REG_SPARE, 64'h7FFF, 1'b1, '{1'b0, drac_pkg::CLASS_NONE}},
    '{ROW_CFG, drac_pkg::REG_RANGE_PAIR_1, 64'h1000_9000_FFFF_FFFF, 1'b0, NO_CHECK},
    '{ROW_CFG, drac_pkg::REG_RANGE_PAIR_0, drac_pkg::RESET_PAIR, 1'b0, NO_CHECK},
    '{ROW_SAMPLE, REG_SPARE, 64'hFFFF, 1'b1, '{1'b0, drac_pkg::CLASS_NONE}},
    '{ROW_SAMPLE, REG_SPARE, 64'h9000, 1'b1, '{1'b0, drac_pkg::CLASS_NONE}},
    '{ROW_CFG, drac_pkg::REG_RANGE_PAIR_3, 64'hFFFF_0000_FFFF_0000, 1'b0, NO_CHECK},
    '{ROW_CFG, drac_pkg::REG_RANGE_PAIR_2, 64'h5678_1234_0000_0000, 1'b0, NO_CHECK},
    '{ROW_SAMPLE, REG_SPARE, 64'h0000, 1'b1, '{1'b1, 4'd4}},
    '{ROW_SAMPLE, REG_SPARE, 64'h2000, 1'b1, '{1'b1, 4'd5}},
    '{ROW_SAMPLE, REG_SPARE, 64'h6000, 1'b1, '{1'b1, 4'd6}},
    '{ROW_CFG, drac_pkg::REG_CHANGE_THRESHOLD, 64'hFFFF, 1'b0, NO_CHECK},
    '{ROW_SAMPLE, REG_SPARE, 64'h0000, 1'b1, '{1'b0, 4'd6}},
    '{ROW_SAMPLE, REG_SPARE, 64'hFFFF, 1'b1, '{1'b0, 4'd6}},
    '{ROW_CFG, drac_pkg::REG_CHANGE_THRESHOLD, 64'h1000, 1'b0, NO_CHECK},
    '{ROW_CFG, drac_pkg::REG_CONFIRM_COUNT, 64'd3, 1'b0, NO_CHECK},
    '{ROW_CFG, drac_pkg::REG_TABLE_SELECTED, 64'd1, 1'b0, NO_CHECK},
    '{ROW_SAMPLE, REG_SPARE, 64'h0000, 1'b1, '{1'b1, 4'd6}},
    '{ROW_SAMPLE, REG_SPARE, 64'h6000, 1'b1, '{1'b1, 4'd6}},
    '{ROW_CFG, drac_pkg::REG_TABLE_SELECTED, 64'd0, 1'b0, NO_CHECK},
    '{ROW_SAMPLE, REG_SPARE, 64'h0000, 1'b0, NO_CHECK},
    '{ROW_SAMPLE, REG_SPARE, 64'h0001, 1'b0, NO_CHECK},
    '{ROW_SAMPLE, REG_SPARE, 64'h0000, 1'b0, NO_CHECK}
  };

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [drac_pkg::SAMPLE_W-1:0]  in_adc_sample = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           out_report;
  logic [drac_pkg::CLASS_W-1:0]   out_class_index;
  logic                           cfg_we = 1'b0;
  logic [drac_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [drac_pkg::PAIR_W-1:0]    cfg_wdata = '0;

  // classifier copy: window table and controls, then debounce state
  logic [drac_pkg::PAIR_W-1:0]   pair_q [4];
  logic                          lock_en;
  logic [drac_pkg::SAMPLE_W-1:0] step_thresh;
  logic [drac_pkg::RUN_W-1:0]    confirm_len;
  logic [drac_pkg::SAMPLE_W-1:0] adc_held;
  logic [drac_pkg::RUN_W-1:0]    run_len;
  logic [drac_pkg::CLASS_W-1:0]  class_held;

  drac_pkg::drac_res_t expected_classes [$];
  int        mismatches = 0;
  int        fresh_items = 0;
  int        idle_cycles = 0;
  bit        quiet_stretch = 1'b0;
  bit        sample_took;

  debounced_adc_range_classifier u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_adc_sample   (in_adc_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_report      (out_report),
    .out_class_index (out_class_index),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [drac_pkg::SAMPLE_W-1:0] sample_gap(
      input logic [drac_pkg::SAMPLE_W-1:0] a,
      input logic [drac_pkg::SAMPLE_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [drac_pkg::CLASS_W-1:0] window_of(
      input logic [drac_pkg::SAMPLE_W-1:0] s);
    logic [drac_pkg::SAMPLE_W-1:0] lo, hi;
    for (int w = 0; w < 8; w++) begin
      lo = pair_q[w / 2][(w % 2) * 32 +: 16];
      hi = pair_q[w / 2][(w % 2) * 32 + 16 +: 16];
      if (lo != drac_pkg::DISABLED_MIN && s >= lo && s <= hi)
        return drac_pkg::CLASS_W'(w);
    end
    return drac_pkg::CLASS_NONE;
  endfunction

  function automatic bit locked();
    return class_held != drac_pkg::CLASS_NONE && lock_en;
  endfunction

  // debounce one sample and classify it once the run confirms
  task automatic classify_step(input logic [drac_pkg::SAMPLE_W-1:0] s,
                               output drac_pkg::drac_res_t res, output bit took);
    logic [drac_pkg::CLASS_W-1:0] cls;
    res.report = 1'b0;
    took = 1'b0;
    if (locked()) begin
      res.report = 1'b1;
    end else if (sample_gap(s, adc_held) > step_thresh) begin
      run_len = run_len + 1'b1;
      if (run_len == confirm_len) begin
        run_len  = '0;
        adc_held = s;
        took     = 1'b1;
        cls      = window_of(s);
        if (cls != class_held) begin
          class_held = cls;
          res.report = 1'b1;
        end
      end
    end else begin
      run_len = '0;
    end
    res.class_index = class_held;
  endtask

  function automatic logic [31:0] rand_window();
    logic [drac_pkg::SAMPLE_W-1:0] lo, hi;
    int pick, top;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      lo = drac_pkg::DISABLED_MIN;
      hi = 16'($urandom);
    end else if (pick < 25) begin
      lo = 16'($urandom_range(1, 65535));
      hi = 16'($urandom_range(0, lo - 1));
    end else if (pick < 30) begin
      lo = '0;
      hi = '1;
    end else begin
      lo  = 16'($urandom);
      top = int'(lo) + int'($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 4000));
      hi  = (top > 65535) ? 16'hFFFF : top[15:0];
    end
    return {hi, lo};
  endfunction

  function automatic logic [drac_pkg::SAMPLE_W-1:0] pick_in_window();
    logic [drac_pkg::SAMPLE_W-1:0] lo, hi;
    int w;
    for (int tries = 0; tries < 8; tries++) begin
      w  = $urandom_range(0, 7);
      lo = pair_q[w / 2][(w % 2) * 32 +: 16];
      hi = pair_q[w / 2][(w % 2) * 32 + 16 +: 16];
      if (lo != drac_pkg::DISABLED_MIN && lo <= hi) return 16'($urandom_range(lo, hi));
    end
    return 16'($urandom);
  endfunction

  task automatic write_reg(input logic [drac_pkg::CFG_IDX_W-1:0] idx,
                           input logic [drac_pkg::PAIR_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      drac_pkg::REG_RANGE_PAIR_0, drac_pkg::REG_RANGE_PAIR_1,
      drac_pkg::REG_RANGE_PAIR_2, drac_pkg::REG_RANGE_PAIR_3: pair_q[idx[1:0]] = val;
      drac_pkg::REG_TABLE_SELECTED:   lock_en = val[0];
      drac_pkg::REG_CHANGE_THRESHOLD: step_thresh = val[drac_pkg::SAMPLE_W-1:0];
      drac_pkg::REG_CONFIRM_COUNT:    confirm_len = val[drac_pkg::RUN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic push_sample(input logic [drac_pkg::SAMPLE_W-1:0] s, input logic typed,
                             input drac_pkg::drac_res_t typed_res);
    drac_pkg::drac_res_t res;
    bit took;
    in_valid      <= 1'b1;
    in_adc_sample <= s;
    do @(posedge clk); while (!in_ready);
    classify_step(s, res, took);
    expected_classes.push_back(typed ? typed_res : res);
    sample_took = took;
    if (!quiet_stretch && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drive_fresh(input logic [drac_pkg::SAMPLE_W-1:0] s);
    fresh_items++;
    push_sample(s, 1'b0, NO_CHECK);
  endtask

  // hold the request channel quiet until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_classes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= quiet_stretch || ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk) begin
    drac_pkg::drac_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_classes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing outstanding: report %0b class %0d",
                   out_report, out_class_index);
      end else begin
        want = expected_classes.pop_front();
        if (want.report !== out_report || want.class_index !== out_class_index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("class mismatch: expected report %0b class %0d, got report %0b class %0d",
                     want.report, want.class_index, out_report, out_class_index);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("tb_debounced_adc_range_classifier failed");
      $finish;
    end
  end

  initial begin
    int pick, need, cap, far;
    logic [drac_pkg::SAMPLE_W-1:0] target;

    pair_q      = '{default: drac_pkg::RESET_PAIR};
    lock_en     = 1'b0;
    step_thresh = drac_pkg::RESET_THRESHOLD;
    confirm_len = drac_pkg::RESET_CONFIRM;
    adc_held    = '0;
    run_len     = '0;
    class_held  = drac_pkg::CLASS_NONE;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < SCRIPT_LEN; r++) begin
      if (SCRIPT[r].kind == ROW_CFG) begin
        settle();
        write_reg(SCRIPT[r].idx, SCRIPT[r].data);
      end else begin
        push_sample(SCRIPT[r].data[drac_pkg::SAMPLE_W-1:0], SCRIPT[r].typed,
                    SCRIPT[r].res);
      end
    end

    // confirm count of zero: the run wraps and accepts on the 256th differing sample
    settle();
    write_reg(drac_pkg::REG_CHANGE_THRESHOLD, 64'd0);
    write_reg(drac_pkg::REG_CONFIRM_COUNT, 64'd0);
    repeat (258) push_sample(adc_held ^ 16'h8000, 1'b0, NO_CHECK);

    // drop the confirm count below a run in progress: the run must wrap first
    settle();
    write_reg(drac_pkg::REG_CONFIRM_COUNT, 64'd200);
    repeat (6) push_sample(adc_held ^ 16'h8000, 1'b0, NO_CHECK);
    settle();
    write_reg(drac_pkg::REG_CONFIRM_COUNT, 64'd2);
    repeat (256) push_sample(adc_held ^ 16'h8000, 1'b0, NO_CHECK);

    while (fresh_items < RANDOM_ITEMS) begin
      settle();
      for (int k = 0; k < 4; k++)
        if ($urandom_range(0, 1))
          write_reg(drac_pkg::REG_RANGE_PAIR_0 + k[2:0], {rand_window(), rand_window()});
      pick = $urandom_range(0, 99);
      write_reg(drac_pkg::REG_CHANGE_THRESHOLD,
                64'(pick < 35 ? $urandom_range(0, 64) : pick < 65 ? $urandom_range(65, 3000) :
                    pick < 75 ? 0 : pick < 82 ? 65535 : $urandom_range(0, 65535)));
      pick = $urandom_range(0, 99);
      write_reg(drac_pkg::REG_CONFIRM_COUNT,
                64'(pick < 55 ? $urandom_range(1, 4) : pick < 85 ? $urandom_range(5, 12) :
                    pick < 92 ? $urandom_range(13, 40) : pick < 96 ? 255 : 1));
      write_reg(drac_pkg::REG_TABLE_SELECTED, 64'($urandom_range(0, 99) < 30));
      if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, {$urandom, $urandom});

      for (int q = $urandom_range(3, 10); q > 0 && !locked(); q--) begin
        quiet_stretch = fresh_items >= 400 && fresh_items < 650;
        need = (confirm_len == 0) ? 256 : confirm_len;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // well-formed run towards a target far enough from the held sample
          target = $urandom_range(0, 1) ? pick_in_window() : 16'($urandom);
          if (sample_gap(target, adc_held) <= step_thresh) begin
            far = int'(adc_held) + int'(step_thresh) + 1 + int'($urandom_range(0, 50));
            if (far > 65535)
              far = int'(adc_held) - int'(step_thresh) - 1 - int'($urandom_range(0, 50));
            if (far >= 0 && far <= 65535) target = far[15:0];
          end
          cap = need + 1;
          if (need > 24 && $urandom_range(0, 3) != 0) cap = 24;
          for (int n = 0; n < cap && !locked(); n++) begin
            far = int'(target) + int'($urandom_range(0, 6)) - 3;
            drive_fresh(far < 0 ? 16'h0000 : far > 65535 ? 16'hFFFF : far[15:0]);
            if (sample_took) break;
          end
        end else if (pick < 85) begin
          // run cut short by a sample close to the held one
          for (int n = $urandom_range(1, need > 2 ? need - 1 : 1); n > 0 && !locked(); n--)
            drive_fresh(adc_held ^ 16'h8000 ^ 16'($urandom_range(0, 255)));
          far = int'($urandom_range(0, step_thresh < 16 ? step_thresh : 16));
          far = (int'(adc_held) + far > 65535) ? int'(adc_held) - far : int'(adc_held) + far;
          if (!locked()) drive_fresh(far[15:0]);
        end else begin
          for (int n = $urandom_range(1, 6); n > 0 && !locked(); n--) begin
            pick = $urandom_range(0, 9);
            drive_fresh(pick == 0 ? 16'h0000 : pick == 1 ? 16'hFFFF : 16'($urandom));
          end
        end
      end
      if (locked())
        repeat ($urandom_range(1, 4)) push_sample(16'($urandom), 1'b0, NO_CHECK);
    end
    quiet_stretch = 1'b0;

    settle();
    if (mismatches == 0 && expected_classes.size() == 0)
      $display("tb_debounced_adc_range_classifier passed");
    else
      $display("tb_debounced_adc_range_classifier failed");
    $finish;
  end

endmodule
